@@ rtl/bitmap_block_allocator_unit_defines.svh @@
// Assertion macros for the bitmap block allocator checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define BBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/bba_pkg.sv @@
// Shared types and constants for the bitmap block allocator.
// No dependencies.
`timescale 1ns / 1ps
package bba_pkg;
  localparam int COUNT_W   = 13;
  localparam int ADDR_W    = 32;
  localparam int WORD_BITS = 32;
  localparam int WORD_SH   = 5;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_TEST  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_ZERO_LEN = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] run_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  base_address;
    logic               block_used;
    logic [COUNT_W-1:0] free_blocks;
  } out_item_t;

  typedef logic [COUNT_W-1:0] cfg_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic scan_start;
    logic scan;
    logic rng_free;
    logic rng_rd;
    logic rng_wr;
    logic test_rd;
    logic finish;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       clr_last;
    logic       fc_zero;
    logic       len_zero;
    logic       span_empty;
    logic       found_now;
    logic       scan_over;
    logic       rng_empty;
    logic       rng_last;
    logic       out_free;
  } dp_sts_t;
endpackage

@@ rtl/bba_chan_if.sv @@
// Valid/ready channel carrying one payload type per transaction.
// Depends on nothing; payload types come from bba_pkg at instantiation.
`timescale 1ns / 1ps
interface bba_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/bba_ctrl.sv @@
// Sequencer for the allocator: clear pass, scan, read-modify-write, result.
// Depends on bba_pkg.
`timescale 1ns / 1ps
module bba_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bba_pkg::dp_sts_t sts_i,
  output bba_pkg::dp_cmd_t cmd_o
);
  import bba_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_SCAN, S_RNG_RD, S_RNG_WR, S_TEST, S_DONE
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.cmd)
          CMD_ALLOC: begin
            if (sts_i.fc_zero || sts_i.len_zero || sts_i.span_empty) begin
              state_d = S_DONE;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
          end
          CMD_FREE: begin
            cmd_o.rng_free = 1'b1;
            state_d        = sts_i.rng_empty ? S_DONE : S_RNG_RD;
          end
          CMD_TEST: begin
            cmd_o.test_rd = 1'b1;
            state_d       = S_TEST;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.found_now) state_d = S_RNG_RD;
        else if (sts_i.scan_over) state_d = S_DONE;
      end
      S_RNG_RD: begin
        cmd_o.rng_rd = 1'b1;
        state_d      = S_RNG_WR;
      end
      S_RNG_WR: begin
        cmd_o.rng_wr = 1'b1;
        state_d      = sts_i.rng_last ? S_DONE : S_RNG_RD;
      end
      S_TEST: state_d = S_DONE;
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

@@ rtl/bba_dp.sv @@
// Datapath: bitmap memory, first-fit word evaluator, range mask unit,
// free counter, configuration and result registers. Depends on bba_pkg.
`timescale 1ns / 1ps
module bba_dp #(
  parameter int MAX_BLOCKS  = 4096,
  parameter int BLOCK_BYTES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bba_pkg::in_item_t   in_data_i,
  input  logic                cfg_valid_i,
  input  bba_pkg::cfg_item_t  cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bba_pkg::out_item_t  out_data_o,
  input  bba_pkg::dp_cmd_t    cmd_i,
  output bba_pkg::dp_sts_t    sts_o
);
  import bba_pkg::*;

  localparam int NW         = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA         = (NW > 1) ? $clog2(NW) : 1;
  localparam longint STORE_BITS = longint'(NW) * WORD_BITS;
  localparam int OFF_W      = $clog2(BLOCK_BYTES);
  localparam int FB_W       = ADDR_W - OFF_W;
  localparam int MAXC       = (MAX_BLOCKS > 8191) ? 8191 : MAX_BLOCKS;
  localparam int WC_W       = COUNT_W - WORD_SH;

  // configuration and captured item
  logic [COUNT_W-1:0] bc_q;
  in_item_t           item_q;
  logic [COUNT_W-1:0] fc_q, fc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= COUNT_W'(4096);
    end else if (cfg_valid_i) begin
      bc_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
  end

  logic [COUNT_W-1:0] lim, len;
  logic [FB_W-1:0]    first;
  assign lim   = (bc_q > COUNT_W'(MAXC)) ? COUNT_W'(MAXC) : bc_q;
  assign len   = item_q.run_length;
  assign first = item_q.address[ADDR_W-1:OFF_W];

  // bitmap memory
  logic [WORD_BITS-1:0] mem_q [NW];
  logic [WORD_BITS-1:0] rd_q, wd;
  logic [WA-1:0]        ra, wa, clr_q;
  logic                 re, we;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    if (re) rd_q <= mem_q[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + WA'(1);
    end
  end

  // scan state
  logic [WC_W-1:0]    wcnt_q, ew_q;
  logic               sv_q, found_q;
  logic [COUNT_W:0]   run_q;
  logic [COUNT_W-1:0] start_q;
  logic [WC_W-1:0]    span_w;
  assign span_w = lim[COUNT_W-1:WORD_SH];

  logic [COUNT_W:0]   run_i [WORD_BITS];
  logic [WORD_BITS-1:0] hit;
  logic               hit_any, has;
  logic [WORD_SH-1:0] p, idx;
  logic [COUNT_W-1:0] start_now;

  // per-bit free run length ending at each bit, then first bit that completes the run
  always_comb begin
    has     = 1'b0;
    p       = '0;
    idx     = '0;
    hit_any = 1'b0;
    for (int i = 0; i < WORD_BITS; i++) begin
      has = 1'b0;
      p   = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
        if (j <= i && rd_q[j]) begin
          has = 1'b1;
          p   = WORD_SH'(j);
        end
      end
      run_i[i] = has ? ((COUNT_W+1)'(i) - (COUNT_W+1)'(p))
                     : (run_q + (COUNT_W+1)'(i) + (COUNT_W+1)'(1));
      hit[i]   = !rd_q[i] && (run_i[i] >= {1'b0, len});
    end
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        idx     = WORD_SH'(i);
        hit_any = 1'b1;
      end
    end
  end
  assign start_now = {ew_q, idx} + COUNT_W'(1) - len;

  // free range, clipped to the managed limit
  logic               free_in;
  logic [COUNT_W:0]   hi_sum;
  logic [COUNT_W-1:0] lo_f, hi_f, cnt_f;
  assign free_in = {{(ADDR_W-FB_W){1'b0}}, first} < ADDR_W'(lim);
  assign lo_f    = COUNT_W'(first);
  assign hi_sum  = {1'b0, lo_f} + {1'b0, len};
  assign hi_f    = (hi_sum > {1'b0, lim}) ? lim : hi_sum[COUNT_W-1:0];
  assign cnt_f   = (free_in && len != '0) ? (hi_f - lo_f) : '0;

  // range read-modify-write
  logic [COUNT_W-1:0]   lo_q, hi_q, hi_m1;
  logic [WC_W-1:0]      rw_q;
  logic [WORD_SH-1:0]   lo_off, hi_off;
  logic [WORD_BITS-1:0] mask;
  assign hi_m1  = hi_q - COUNT_W'(1);
  assign lo_off = (rw_q == lo_q[COUNT_W-1:WORD_SH]) ? lo_q[WORD_SH-1:0] : '0;
  assign hi_off = (rw_q == hi_m1[COUNT_W-1:WORD_SH]) ? hi_m1[WORD_SH-1:0] : '1;
  assign mask   = (32'hFFFF_FFFF << lo_off) & (32'hFFFF_FFFF >> (5'd31 - hi_off));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcnt_q  <= '0;
      ew_q    <= '0;
      sv_q    <= 1'b0;
      found_q <= 1'b0;
      run_q   <= '0;
    end else begin
      if (cmd_i.load) found_q <= 1'b0;
      if (cmd_i.scan_start) begin
        wcnt_q <= '0;
        ew_q   <= '0;
        sv_q   <= 1'b0;
        run_q  <= '0;
      end else if (cmd_i.scan) begin
        sv_q <= (wcnt_q != span_w);
        if (wcnt_q != span_w) wcnt_q <= wcnt_q + WC_W'(1);
        if (sv_q) begin
          ew_q  <= ew_q + WC_W'(1);
          run_q <= run_i[WORD_BITS-1];
          if (hit_any) found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && sv_q && hit_any) begin
      start_q <= start_now;
      lo_q    <= start_now;
      hi_q    <= start_now + len;
      rw_q    <= start_now[COUNT_W-1:WORD_SH];
    end else if (cmd_i.rng_free) begin
      lo_q <= lo_f;
      hi_q <= hi_f;
      rw_q <= lo_f[COUNT_W-1:WORD_SH];
    end else if (cmd_i.rng_wr) begin
      rw_q <= rw_q + WC_W'(1);
    end
  end

  // memory port selection
  logic test_in;
  assign test_in = longint'(first) < STORE_BITS;

  always_comb begin
    re = 1'b0;
    ra = WA'(wcnt_q);
    we = 1'b0;
    wa = WA'(rw_q);
    wd = (item_q.command == CMD_ALLOC) ? (rd_q | mask) : (rd_q & ~mask);
    if (cmd_i.clear) begin
      we = 1'b1;
      wa = clr_q;
      wd = 32'hFFFF_FFFF;
    end else if (cmd_i.rng_wr) begin
      we = 1'b1;
    end
    if (cmd_i.scan && wcnt_q != span_w) begin
      re = 1'b1;
    end else if (cmd_i.rng_rd) begin
      re = 1'b1;
      ra = WA'(rw_q);
    end else if (cmd_i.test_rd && test_in) begin
      re = 1'b1;
      ra = WA'(first >> WORD_SH);
    end
  end

  // result and free counter
  logic               out_valid_q;
  out_item_t          out_q;
  logic [COUNT_W:0]   fsum;
  logic               used;
  assign fsum = {1'b0, fc_q} + {1'b0, cnt_f};
  assign used = test_in ? rd_q[first[WORD_SH-1:0]] : 1'b1;

  always_comb begin
    fc_d = fc_q;
    case (item_q.command)
      CMD_ALLOC: if (fc_q != '0 && len != '0 && found_q) begin
        fc_d = (fc_q > len) ? (fc_q - len) : '0;
      end
      CMD_FREE: fc_d = (fsum > {1'b0, lim}) ? lim : fsum[COUNT_W-1:0];
      default: fc_d = fc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        fc_q        <= fc_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.status       <= ST_OK;
      out_q.base_address <= '0;
      out_q.block_used   <= 1'b0;
      out_q.free_blocks  <= fc_d;
      case (item_q.command)
        CMD_ALLOC: begin
          if (fc_q == '0) out_q.status <= ST_NOSPACE;
          else if (len == '0) out_q.status <= ST_ZERO_LEN;
          else if (!found_q) out_q.status <= ST_NOSPACE;
          else out_q.base_address <= ADDR_W'(start_q) << OFF_W;
        end
        CMD_TEST: out_q.block_used <= used;
        default: out_q.block_used <= 1'b0;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o            = '0;
    sts_o.cmd        = item_q.command;
    sts_o.clr_last   = (clr_q == WA'(NW - 1));
    sts_o.fc_zero    = (fc_q == '0);
    sts_o.len_zero   = (len == '0);
    sts_o.span_empty = (span_w == '0);
    sts_o.found_now  = sv_q && hit_any;
    sts_o.scan_over  = (wcnt_q == span_w) && !sv_q;
    sts_o.rng_empty  = !free_in || (len == '0);
    sts_o.rng_last   = (rw_q == hi_m1[COUNT_W-1:WORD_SH]);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end
endmodule

@@ rtl/bitmap_block_allocator_unit.sv @@
// Bitmap block allocator top: one item at a time, one result per item.
// Alloc scans the bitmap one word per cycle through the single memory read
// port, then reads and writes back each word the run touches, or is rejected
// early; free reads and writes back each word of its range. After reset a
// clear pass fills the bitmap with ones before the first item is taken;
// config writes always go.
`timescale 1ns / 1ps
module bitmap_block_allocator_unit #(
  parameter int MAX_BLOCKS  = 4096,
  parameter int BLOCK_BYTES = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bba_chan_if.sink   in_ch,
  bba_chan_if.source out_ch,
  bba_chan_if.sink   cfg_ch
);
  import bba_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic    in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  bba_dp #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_ch.data),
    .cfg_valid_i (cfg_ch.valid),
    .cfg_data_i  (cfg_ch.data),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_o  (out_ch.data),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts)
  );
endmodule

@@ rtl/bba_checker.sv @@
// Port-level checks on the allocator result channel, bound to the top level.
// Depends on bba_pkg and bitmap_block_allocator_unit_defines.svh.
`timescale 1ns / 1ps
`include "bitmap_block_allocator_unit_defines.svh"
module bba_checker #(
  parameter int MAX_BLOCKS = 4096
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input bba_pkg::out_item_t  out_data_i
);
  import bba_pkg::*;

  `BBA_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))
  `BBA_ASSERT_NOW(a_base_ok, out_valid_i && out_data_i.base_address != '0, out_data_i.status == ST_OK)
  `BBA_ASSERT_NOW(a_used_ok, out_valid_i && out_data_i.block_used, out_data_i.status == ST_OK)
  `BBA_ASSERT_NOW(a_free_cap, out_valid_i, 32'(out_data_i.free_blocks) <= 32'(MAX_BLOCKS))
endmodule

bind bitmap_block_allocator_unit bba_checker #(.MAX_BLOCKS(MAX_BLOCKS)) u_bba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_data_i  (out_ch.data)
);
